@@ src/arct_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the asynchronous request completion table.
// Used by the top level and its port checker; depends on nothing else.
package arct_pkg;

    localparam int SLOTS_DEF  = 64;
    localparam int SLOT_W     = 6;
    localparam int IDENT_W    = 64;
    localparam int IN_DATA_W  = 344;
    localparam int OUT_DATA_W = 344;

    typedef enum logic [1:0] {
        REQ_SUBMIT   = 2'd0,
        REQ_TAKE     = 2'd1,
        REQ_COMPLETE = 2'd2,
        REQ_WAIT     = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_NOT_READY = 3'd3,
        STAT_BAD_SLOT  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_PENDING = 2'd1,
        SLOT_DONE    = 2'd2
    } slot_state_t;

    // Input word, highest field first.
    typedef struct packed {
        logic [1:0]         pad;
        logic [63:0]        wait_id;
        logic signed [63:0] io_outcome;
        logic [5:0]         slot_index;
        logic [31:0]        process_id;
        logic [63:0]        buffer_address;
        logic [31:0]        byte_count;
        logic [62:0]        file_offset;
        logic               io_opcode;
        logic [15:0]        file_descriptor;
    } in_word_t;

    // Result word, highest field first.
    typedef struct packed {
        logic [1:0]         pad;
        logic signed [63:0] io_result;
        logic [31:0]        out_process;
        logic [63:0]        out_buffer;
        logic [31:0]        out_count;
        logic [62:0]        out_offset;
        logic               out_opcode;
        logic [15:0]        out_descriptor;
        logic [5:0]         out_slot;
        logic [63:0]        request_id;
    } out_word_t;

    // Request record held per slot.
    typedef struct packed {
        logic [31:0] process_id;
        logic [63:0] buffer_address;
        logic [31:0] byte_count;
        logic [62:0] file_offset;
        logic        io_opcode;
        logic [15:0] file_descriptor;
    } slot_rec_t;

endpackage

@@ src/async_request_completion_table.sv @@
`timescale 1ns / 1ps
// Submit and wait scan the slot table one slot per cycle from slot 0 up to the
// matching slot or the last slot.
// One word at a time: the block is busy until its result is loaded into the output
// register, which waits while an earlier result is still stalled there.
// Reset: a clearing pass marks every slot free before s_axis_tready rises.
//
// Slot table top level: request, ident, outcome, state and pending-FIFO memories
// under one sequencer. Depends on arct_pkg.
module async_request_completion_table
    import arct_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // fields from bit 0: file_descriptor, io_opcode, file_offset, byte_count,
    // buffer_address, process_id, slot_index, io_outcome, wait_id, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // fields from bit 0: req_type
    input  logic [1:0]            s_axis_tuser,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // fields from bit 0: request_id, out_slot, out_descriptor, out_opcode,
    // out_offset, out_count, out_buffer, out_process, io_result, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // fields from bit 0: status_code
    output logic [2:0]            m_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready
);

    localparam int AW = $clog2(SLOTS);
    localparam int FW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,     // post-reset sweep of the state memory
        ST_IDLE,      // ready for a word
        ST_SCAN,      // walk slots for a free slot or a done ident
        ST_CPL_READ,  // state read of the named slot in flight
        ST_CPL_DATA,  // check and mark the slot done
        ST_POP_ADDR,  // FIFO head read is ready, advance the head
        ST_POP_READ,  // slot record read in flight
        ST_POP_DATA,  // form the take-next result
        ST_OUT        // hold the result until the output register is free
    } seq_state_t;

    // ---------------------------------------------------------------- memories
    slot_state_t        state_mem [SLOTS];
    logic [IDENT_W-1:0] ident_mem [SLOTS];
    logic [63:0]        outcome_mem [SLOTS];
    slot_rec_t          rec_mem [SLOTS];
    logic [AW-1:0]      fifo_mem [SLOTS];

    slot_state_t        state_rd_reg;
    logic [IDENT_W-1:0] ident_rd_reg;
    logic [63:0]        outcome_rd_reg;
    slot_rec_t          rec_rd_reg;
    logic [AW-1:0]      fifo_rd_reg;

    // write controls, driven by the sequencer
    logic               st_we;
    logic [AW-1:0]      st_wa;
    slot_state_t        st_wd;
    logic               sub_we;      // submit stamp: record and ident; the cleared outcome goes via out_we
    logic               out_we;
    logic [AW-1:0]      out_wa;
    logic [63:0]        out_wd;
    logic               fifo_we;

    // ---------------------------------------------------------------- registers
    seq_state_t         state_reg, state_next;
    logic [AW-1:0]      addr_reg, addr_next;     // read address of the state, ident, outcome and record memories
    logic [AW-1:0]      data_idx_reg;            // slot that the read data belongs to
    logic               probe_reg, probe_next;   // read data is a valid scan probe
    req_kind_t          kind_reg, kind_next;
    in_word_t           req_reg, req_next;
    out_word_t          res_reg, res_next;
    status_t            res_stat_reg, res_stat_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [IDENT_W-1:0] ident_reg, ident_next;
    logic               m_valid_reg, m_valid_next;
    out_word_t          m_data_reg, m_data_next;
    status_t            m_stat_reg, m_stat_next;

    in_word_t           s_word;
    logic               scan_hit;
    logic               slot_in_range;

    assign s_word        = in_word_t'(s_axis_tdata);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(m_data_reg);
    assign m_axis_tuser  = m_stat_reg;

    // A submit wants the first free slot; a wait wants a done slot with the ident.
    assign scan_hit = (kind_reg == REQ_SUBMIT) ? (state_rd_reg == SLOT_FREE)
                    : ((state_rd_reg == SLOT_DONE) && (ident_rd_reg == req_reg.wait_id));
    assign slot_in_range = (32'(req_reg.slot_index) < 32'(SLOTS));

    // Memories: one write port each, read data registered every cycle.
    always_ff @(posedge aclk) begin
        if (st_we) begin
            state_mem[st_wa] <= st_wd;
        end
        state_rd_reg <= state_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (sub_we) begin
            ident_mem[data_idx_reg] <= ident_reg;
        end
        ident_rd_reg <= ident_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (out_we) begin
            outcome_mem[out_wa] <= out_wd;
        end
        outcome_rd_reg <= outcome_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (sub_we) begin
            rec_mem[data_idx_reg] <= '{
                process_id:      req_reg.process_id,
                buffer_address:  req_reg.buffer_address,
                byte_count:      req_reg.byte_count,
                file_offset:     req_reg.file_offset,
                io_opcode:       req_reg.io_opcode,
                file_descriptor: req_reg.file_descriptor
            };
        end
        rec_rd_reg <= rec_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_mem[tail_reg] <= data_idx_reg;
        end
        fifo_rd_reg <= fifo_mem[head_reg];
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        probe_next    = probe_reg;
        kind_next     = kind_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        res_stat_next = res_stat_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        ident_next    = ident_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_stat_next   = m_stat_reg;

        st_we   = 1'b0;
        st_wa   = data_idx_reg;
        st_wd   = SLOT_FREE;
        sub_we  = 1'b0;
        out_we  = 1'b0;
        out_wa  = data_idx_reg;
        out_wd  = '0;
        fifo_we = 1'b0;

        // drop the output word once taken
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                st_we = 1'b1;
                st_wa = addr_reg;
                st_wd = SLOT_FREE;
                if (addr_reg == LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end

            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    req_next      = s_word;
                    kind_next     = req_kind_t'(s_axis_tuser);
                    probe_next    = 1'b0;
                    res_next      = '0;
                    res_stat_next = STAT_OK;
                    unique case (req_kind_t'(s_axis_tuser))
                        REQ_SUBMIT, REQ_WAIT: begin
                            addr_next  = '0;
                            state_next = ST_SCAN;
                        end
                        REQ_TAKE: begin
                            if (fill_reg == '0) begin
                                res_stat_next = STAT_EMPTY;
                                state_next    = ST_OUT;
                            end else begin
                                state_next = ST_POP_ADDR;
                            end
                        end
                        REQ_COMPLETE: begin
                            addr_next  = AW'(s_word.slot_index);
                            state_next = ST_CPL_READ;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                probe_next = 1'b1;
                if (addr_reg != LAST) begin
                    addr_next = addr_reg + AW'(1);
                end
                if (probe_reg) begin
                    if (scan_hit) begin
                        state_next = ST_OUT;
                        if (kind_reg == REQ_SUBMIT) begin
                            if (fill_reg == FW'(SLOTS)) begin
                                res_stat_next = STAT_FULL;
                            end else begin
                                // claim the slot, stamp it, queue it
                                st_we   = 1'b1;
                                st_wd   = SLOT_PENDING;
                                sub_we  = 1'b1;
                                out_we  = 1'b1;
                                out_wd  = '0;
                                fifo_we = 1'b1;
                                tail_next  = (tail_reg == LAST) ? '0 : tail_reg + AW'(1);
                                fill_next  = fill_reg + FW'(1);
                                ident_next = ident_reg + IDENT_W'(1);
                                res_next.request_id = ident_reg;
                                res_next.out_slot   = SLOT_W'(data_idx_reg);
                            end
                        end else begin
                            // release the matched slot
                            st_we = 1'b1;
                            st_wd = SLOT_FREE;
                            res_next.request_id = ident_rd_reg;
                            res_next.io_result  = outcome_rd_reg;
                        end
                    end else if (data_idx_reg == LAST) begin
                        state_next    = ST_OUT;
                        res_stat_next = (kind_reg == REQ_SUBMIT) ? STAT_FULL : STAT_NOT_READY;
                    end
                end
            end

            ST_CPL_READ: begin
                state_next = ST_CPL_DATA;
            end

            ST_CPL_DATA: begin
                state_next = ST_OUT;
                if (slot_in_range && (state_rd_reg == SLOT_PENDING)) begin
                    st_we  = 1'b1;
                    st_wa  = addr_reg;
                    st_wd  = SLOT_DONE;
                    out_we = 1'b1;
                    out_wa = addr_reg;
                    out_wd = req_reg.io_outcome;
                end else begin
                    res_stat_next = STAT_BAD_SLOT;
                end
            end

            ST_POP_ADDR: begin
                addr_next  = fifo_rd_reg;
                head_next  = (head_reg == LAST) ? '0 : head_reg + AW'(1);
                fill_next  = fill_reg - FW'(1);
                state_next = ST_POP_READ;
            end

            ST_POP_READ: begin
                state_next = ST_POP_DATA;
            end

            ST_POP_DATA: begin
                res_next.request_id     = ident_rd_reg;
                res_next.out_slot       = SLOT_W'(addr_reg);
                res_next.out_descriptor = rec_rd_reg.file_descriptor;
                res_next.out_opcode     = rec_rd_reg.io_opcode;
                res_next.out_offset     = rec_rd_reg.file_offset;
                res_next.out_count      = rec_rd_reg.byte_count;
                res_next.out_buffer     = rec_rd_reg.buffer_address;
                res_next.out_process    = rec_rd_reg.process_id;
                state_next              = ST_OUT;
            end

            ST_OUT: begin
                // load the output register when it is empty or being drained
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_stat_next  = res_stat_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            probe_reg   <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            ident_reg   <= IDENT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            probe_reg   <= probe_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            ident_reg   <= ident_next;
            m_valid_reg <= m_valid_next;
        end
        data_idx_reg <= addr_reg;
        kind_reg     <= kind_next;
        req_reg      <= req_next;
        res_reg      <= res_next;
        res_stat_reg <= res_stat_next;
        m_data_reg   <= m_data_next;
        m_stat_reg   <= m_stat_next;
    end

endmodule

@@ src/arct_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the request completion table, bound to the top level.
// Depends on arct_pkg for the status codes.
module arct_checker
    import arct_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [1:0]            s_axis_tuser,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [2:0]            m_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready
);

    // reset starts the clearing pass: no result, no intake right after it
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && !s_axis_tready)
        else $error("output valid or input ready right after reset");

    // one word in flight: intake closes right after an accepted word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready in the cycle after an accepted word");

    // any failure status carries an all-zero result word
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tdata == '0)
        else $error("non-zero result data with a failure status");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

endmodule

bind async_request_completion_table arct_checker u_arct_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
